// ===== rtl/core/note_step_sequencer_defines.svh =====
// Assertion macros used by the checker file of the step sequencer.
`ifndef NOTE_STEP_SEQUENCER_DEFINES_SVH
`define NOTE_STEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define NSS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define NSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/nss_pkg.sv =====
// Types, constants and lookup tables of the step sequencer.
`timescale 1ns / 1ps
package nss_pkg;

	localparam int NOTE_ROWS_DEF    = 12;
	localparam int STEP_COLUMNS_DEF = 16;

	localparam int TEMPO_W = 5;
	localparam int ROW_IDX_W = 5;   // covers up to 32 note rows
	localparam int GATE_W = 12;
	localparam int FREQ_W = 10;
	localparam int ACC_W = 5;

	localparam logic [TEMPO_W-1:0] TEMPO_RESET = 5'd9;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 5'd20;
	localparam logic [GATE_W-1:0]  AUDITION_RESET = 12'd200;

	typedef enum logic [2:0] {
		OP_TICK       = 3'd0,
		OP_TOGGLE     = 3'd1,
		OP_PLAY       = 3'd2,
		OP_CLEAR      = 3'd3,
		OP_TEMPO_DOWN = 3'd4,
		OP_TEMPO_UP   = 3'd5
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] row;
		logic [3:0] col;
	} item_t;

	typedef struct packed {
		logic              tone_on;
		logic [FREQ_W-1:0] tone_freq;
		logic              tone_start;
		logic              tone_stop;
		logic [3:0]        step_now;
		logic              is_playing;
		logic [7:0]        tempo_bpm;
	} res_t;

	function automatic logic [7:0] bpm_of(input logic [TEMPO_W-1:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0:  v = 8'd60;
			5'd1:  v = 8'd65;
			5'd2:  v = 8'd70;
			5'd3:  v = 8'd75;
			5'd4:  v = 8'd80;
			5'd5:  v = 8'd85;
			5'd6:  v = 8'd90;
			5'd7:  v = 8'd95;
			5'd8:  v = 8'd100;
			5'd9:  v = 8'd105;
			5'd10: v = 8'd110;
			5'd11: v = 8'd115;
			5'd12: v = 8'd120;
			5'd13: v = 8'd125;
			5'd14: v = 8'd130;
			5'd15: v = 8'd135;
			5'd16: v = 8'd140;
			5'd17: v = 8'd150;
			5'd18: v = 8'd160;
			5'd19: v = 8'd170;
			default: v = 8'd180;
		endcase
		return v;
	endfunction

	// ticks per step: (6000 / bpm) / 4
	function automatic logic [ACC_W-1:0] tps_of(input logic [TEMPO_W-1:0] idx);
		logic [ACC_W-1:0] v;
		case (idx)
			5'd0:  v = 5'd25;
			5'd1:  v = 5'd23;
			5'd2:  v = 5'd21;
			5'd3:  v = 5'd20;
			5'd4:  v = 5'd18;
			5'd5:  v = 5'd17;
			5'd6:  v = 5'd16;
			5'd7:  v = 5'd15;
			5'd8:  v = 5'd15;
			5'd9:  v = 5'd14;
			5'd10: v = 5'd13;
			5'd11: v = 5'd13;
			5'd12: v = 5'd12;
			5'd13: v = 5'd12;
			5'd14: v = 5'd11;
			5'd15: v = 5'd11;
			5'd16: v = 5'd10;
			5'd17: v = 5'd10;
			5'd18: v = 5'd9;
			default: v = 5'd8;
		endcase
		return v;
	endfunction

	// step gate: ticks per step * 6 / 10
	function automatic logic [3:0] step_gate_of(input logic [TEMPO_W-1:0] idx);
		logic [3:0] v;
		case (idx)
			5'd0:  v = 4'd15;
			5'd1:  v = 4'd13;
			5'd2:  v = 4'd12;
			5'd3:  v = 4'd12;
			5'd4:  v = 4'd10;
			5'd5:  v = 4'd10;
			5'd6:  v = 4'd9;
			5'd7:  v = 4'd9;
			5'd8:  v = 4'd9;
			5'd9:  v = 4'd8;
			5'd10: v = 4'd7;
			5'd11: v = 4'd7;
			5'd12: v = 4'd7;
			5'd13: v = 4'd7;
			5'd14: v = 4'd6;
			5'd15: v = 4'd6;
			5'd16: v = 4'd6;
			5'd17: v = 4'd6;
			5'd18: v = 4'd5;
			default: v = 4'd4;
		endcase
		return v;
	endfunction

	// rows past the table sound the lowest note
	function automatic logic [FREQ_W-1:0] pitch_of(input logic [ROW_IDX_W-1:0] r);
		logic [FREQ_W-1:0] v;
		case (r)
			5'd0:  v = 10'd880;
			5'd1:  v = 10'd784;
			5'd2:  v = 10'd698;
			5'd3:  v = 10'd659;
			5'd4:  v = 10'd587;
			5'd5:  v = 10'd523;
			5'd6:  v = 10'd494;
			5'd7:  v = 10'd440;
			5'd8:  v = 10'd392;
			5'd9:  v = 10'd349;
			5'd10: v = 10'd330;
			default: v = 10'd294;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/note_step_sequencer.sv =====
// An accepted beat is updated in one pass and moves to the result register when free.
// Throughput: one event per cycle unless stalled; input refills while a result waits.
// Rate is set by the single-pass update between the input and result registers.
// Reset (arst_n low): grid clear, stopped, column 0, tempo 105 BPM, silent,
// audition gate 200 ticks, no beats held.
`timescale 1ns / 1ps
module note_step_sequencer #(
	parameter int NOTE_ROWS    = nss_pkg::NOTE_ROWS_DEF,
	parameter int STEP_COLUMNS = nss_pkg::STEP_COLUMNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [nss_pkg::GATE_W-1:0] cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [2:0]                 op,
	input  logic [3:0]                 row,
	input  logic [3:0]                 col,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic                       tone_on,
	output logic [nss_pkg::FREQ_W-1:0] tone_freq,
	output logic                       tone_start,
	output logic                       tone_stop,
	output logic [3:0]                 step_now,
	output logic                       is_playing,
	output logic [7:0]                 tempo_bpm
);
	import nss_pkg::*;

	logic  free, fire;
	item_t item_s1;
	res_t  res, res_s2;

	nss_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (op),
		.row       (row),
		.col       (col),
		.free      (free),
		.fire      (fire),
		.item_s1   (item_s1)
	);

	nss_engine #(
		.NOTE_ROWS    (NOTE_ROWS),
		.STEP_COLUMNS (STEP_COLUMNS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item_s1   (item_s1),
		.res       (res)
	);

	nss_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res       (res),
		.free      (free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.res_s2    (res_s2)
	);

	assign tone_on    = res_s2.tone_on;
	assign tone_freq  = res_s2.tone_freq;
	assign tone_start = res_s2.tone_start;
	assign tone_stop  = res_s2.tone_stop;
	assign step_now   = res_s2.step_now;
	assign is_playing = res_s2.is_playing;
	assign tempo_bpm  = res_s2.tempo_bpm;

endmodule

// ===== rtl/core/nss_in_stage.sv =====
// Input register with valid/stall handshake toward the event source.
`timescale 1ns / 1ps
module nss_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic [2:0]      op,
	input  logic [3:0]      row,
	input  logic [3:0]      col,
	input  logic            free,
	output logic            fire,
	output nss_pkg::item_t  item_s1
);
	import nss_pkg::*;

	logic vld_s1;
	logic load;

	assign fire      = vld_s1 & free;
	assign req_stall = vld_s1 & ~free;
	assign load      = req_valid & ~req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.op  <= op_t'(op);
			item_s1.row <= row;
			item_s1.col <= col;
		end
	end

endmodule

// ===== rtl/core/nss_engine.sv =====
// Sequencer state and the single-pass update for one event beat.
`timescale 1ns / 1ps
module nss_engine #(
	parameter int NOTE_ROWS    = nss_pkg::NOTE_ROWS_DEF,
	parameter int STEP_COLUMNS = nss_pkg::STEP_COLUMNS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [nss_pkg::GATE_W-1:0]   cfg_wdata,
	input  logic                         fire,
	input  nss_pkg::item_t               item_s1,
	output nss_pkg::res_t                res
);
	import nss_pkg::*;

	localparam int COL_W = $clog2(STEP_COLUMNS);

	logic [NOTE_ROWS-1:0][STEP_COLUMNS-1:0] grid_q, grid_d, grid_tgl;
	logic                 run_q, run_d;
	logic                 first_q, first_d;
	logic [COL_W-1:0]     col_q, col_d;
	logic [ACC_W-1:0]     acc_q, acc_d;
	logic [TEMPO_W-1:0]   tidx_q, tidx_d;
	logic                 active_q, active_d;
	logic [GATE_W-1:0]    gate_q, gate_d;
	logic [FREQ_W-1:0]    freq_q, freq_d;
	logic [GATE_W-1:0]    aud_q;

	logic                 started, stopped;
	logic [ACC_W-1:0]     tps, acc_inc;
	logic [COL_W-1:0]     step_col;
	logic                 hit;
	logic [ROW_IDX_W-1:0] hit_row;
	logic                 cell_set;

	assign tps     = tps_of(tidx_q);
	assign acc_inc = acc_q + ACC_W'(1);

	// first step after play lands on column 0
	always_comb begin
		if (first_q) begin
			step_col = '0;
		end else if (col_q == COL_W'(STEP_COLUMNS - 1)) begin
			step_col = '0;
		end else begin
			step_col = col_q + COL_W'(1);
		end
	end

	// lowest active row of the column about to play
	always_comb begin
		hit     = 1'b0;
		hit_row = '0;
		for (int r = NOTE_ROWS - 1; r >= 0; r--) begin
			if (grid_q[r][step_col]) begin
				hit     = 1'b1;
				hit_row = ROW_IDX_W'(r);
			end
		end
	end

	// toggled grid; out-of-range cells match nothing
	always_comb begin
		grid_tgl = grid_q;
		cell_set = 1'b0;
		for (int r = 0; r < NOTE_ROWS; r++) begin
			for (int c = 0; c < STEP_COLUMNS; c++) begin
				if (int'(item_s1.row) == r && int'(item_s1.col) == c) begin
					grid_tgl[r][c] = ~grid_q[r][c];
					cell_set       = ~grid_q[r][c];
				end
			end
		end
	end

	always_comb begin
		grid_d   = grid_q;
		run_d    = run_q;
		first_d  = first_q;
		col_d    = col_q;
		acc_d    = acc_q;
		tidx_d   = tidx_q;
		active_d = active_q;
		gate_d   = gate_q;
		freq_d   = freq_q;
		started  = 1'b0;
		stopped  = 1'b0;
		unique case (item_s1.op)
			OP_TICK: begin
				if (active_q) begin
					if (gate_q <= GATE_W'(1)) begin
						gate_d   = '0;
						active_d = 1'b0;
						stopped  = 1'b1;
					end else begin
						gate_d = gate_q - GATE_W'(1);
					end
				end
				if (run_q) begin
					acc_d = acc_inc;
					if (acc_inc >= tps) begin
						acc_d   = '0;
						col_d   = step_col;
						first_d = 1'b0;
						if (hit) begin
							freq_d   = pitch_of(hit_row);
							active_d = 1'b1;
							gate_d   = GATE_W'(step_gate_of(tidx_q));
							started  = 1'b1;
						end
					end
				end
			end
			OP_TOGGLE: begin
				grid_d = grid_tgl;
				if (cell_set) begin
					freq_d   = pitch_of({1'b0, item_s1.row});
					active_d = 1'b1;
					gate_d   = aud_q;
					started  = 1'b1;
				end
			end
			OP_PLAY: begin
				run_d   = ~run_q;
				col_d   = '0;
				first_d = 1'b1;
				acc_d   = '0;
				if (run_q) begin
					stopped  = active_q;
					active_d = 1'b0;
					gate_d   = '0;
				end
			end
			OP_CLEAR: begin
				grid_d = '0;
			end
			OP_TEMPO_DOWN: begin
				if (tidx_q != '0) begin
					tidx_d = tidx_q - TEMPO_W'(1);
				end
			end
			OP_TEMPO_UP: begin
				if (tidx_q < TEMPO_MAX) begin
					tidx_d = tidx_q + TEMPO_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.tone_on    = active_d;
		res.tone_freq  = freq_d;
		res.tone_start = started;
		res.tone_stop  = stopped;
		res.step_now   = 4'(col_d);
		res.is_playing = run_d;
		res.tempo_bpm  = bpm_of(tidx_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q   <= '0;
			run_q    <= 1'b0;
			first_q  <= 1'b0;
			col_q    <= '0;
			acc_q    <= '0;
			tidx_q   <= TEMPO_RESET;
			active_q <= 1'b0;
			gate_q   <= '0;
			freq_q   <= '0;
		end else if (fire) begin
			grid_q   <= grid_d;
			run_q    <= run_d;
			first_q  <= first_d;
			col_q    <= col_d;
			acc_q    <= acc_d;
			tidx_q   <= tidx_d;
			active_q <= active_d;
			gate_q   <= gate_d;
			freq_q   <= freq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aud_q <= AUDITION_RESET;
		end else if (cfg_we) begin
			aud_q <= cfg_wdata;
		end
	end

endmodule

// ===== rtl/core/nss_out_stage.sv =====
// Result register with valid/stall handshake toward the consumer.
`timescale 1ns / 1ps
module nss_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  nss_pkg::res_t  res,
	output logic           free,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output nss_pkg::res_t  res_s2
);
	import nss_pkg::*;

	logic vld_s2;

	assign rsp_valid = vld_s2;
	assign free      = ~vld_s2 | ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (free) begin
			vld_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== rtl/core/nss_checker.sv =====
// Port-level checks of the step sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "note_step_sequencer_defines.svh"
module nss_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_stall,
	input logic                       rsp_valid,
	input logic                       rsp_stall,
	input logic                       tone_on,
	input logic [nss_pkg::FREQ_W-1:0] tone_freq,
	input logic                       tone_start,
	input logic [3:0]                 step_now,
	input logic                       is_playing,
	input logic [7:0]                 tempo_bpm
);
	// a stalled result beat stays put
	`NSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(tone_freq) && $stable(step_now) && $stable(tempo_bpm), "result beat changed while stalled")
	// a started tone is sounding and has a pitch
	`NSS_ASSERT_IMPL(a_start_sounds, rsp_valid && tone_start, tone_on && tone_freq != '0, "tone start without a sounding tone")
	// the playhead rests at column 0 while stopped
	`NSS_ASSERT_IMPL(a_idle_column, rsp_valid && !is_playing, step_now == 4'd0, "playhead moved while stopped")
	// input backpressure only comes from a held result
	`NSS_ASSERT_IMPL(a_stall_cause, req_stall, rsp_valid && rsp_stall, "input stalled with the result side free")
endmodule

bind note_step_sequencer nss_checker u_nss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_stall  (req_stall),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.tone_on    (tone_on),
	.tone_freq  (tone_freq),
	.tone_start (tone_start),
	.step_now   (step_now),
	.is_playing (is_playing),
	.tempo_bpm  (tempo_bpm)
);

// ===== tb/note_step_sequencer_test.sv =====
// Self-checking testbench for the note step sequencer: directed and random events against a cycle-free predictor.
`timescale 1ns / 1ps
module note_step_sequencer_test;
	import nss_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int ROWS = 12;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] row;
		logic [3:0] col;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [GATE_W-1:0] cfg_wdata = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [2:0] op = '0;
	logic [3:0] row = '0;
	logic [3:0] col = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic tone_on;
	logic [FREQ_W-1:0] tone_freq;
	logic tone_start;
	logic tone_stop;
	logic [3:0] step_now;
	logic is_playing;
	logic [7:0] tempo_bpm;

	note_step_sequencer uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_stall(req_stall),
		.op(op), .row(row), .col(col),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.tone_on(tone_on), .tone_freq(tone_freq), .tone_start(tone_start),
		.tone_stop(tone_stop), .step_now(step_now), .is_playing(is_playing),
		.tempo_bpm(tempo_bpm)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [15:0] cells [ROWS];
	logic running;
	logic [3:0] playhead;
	logic awaiting_first;
	logic [4:0] beat_acc;
	logic [4:0] tempo_sel;
	logic tone_live;
	logic [11:0] gate_left;
	logic [9:0] pitch;
	logic [11:0] aud_ticks;

	beat_t pending_events[$];
	res_t expected_tones[$];
	logic idle_on = 1'b1;
	int send_gap = 0;
	int recv_gap = 0;
	int mismatches = 0;
	int results_seen = 0;
	int starts_seen = 0;
	int stops_seen = 0;
	int both_seen = 0;
	int cycles = 0;

	function automatic int unsigned tempo_hz(input logic [4:0] t);
		case (t)
			5'd0: return 60;    5'd1: return 65;    5'd2: return 70;
			5'd3: return 75;    5'd4: return 80;    5'd5: return 85;
			5'd6: return 90;    5'd7: return 95;    5'd8: return 100;
			5'd9: return 105;   5'd10: return 110;  5'd11: return 115;
			5'd12: return 120;  5'd13: return 125;  5'd14: return 130;
			5'd15: return 135;  5'd16: return 140;  5'd17: return 150;
			5'd18: return 160;  5'd19: return 170;
			default: return 180;
		endcase
	endfunction

	function automatic logic [9:0] pitch_hz(input int r);
		case (r)
			0: return 10'd880;  1: return 10'd784;  2: return 10'd698;
			3: return 10'd659;  4: return 10'd587;  5: return 10'd523;
			6: return 10'd494;  7: return 10'd440;  8: return 10'd392;
			9: return 10'd349;  10: return 10'd330;
			default: return 10'd294;
		endcase
	endfunction

	function automatic int unsigned step_ticks(input logic [4:0] t);
		int unsigned b;
		b = 6000 / tempo_hz(t);
		if (b < 1)
			b = 1;
		b = b / 4;
		if (b < 1)
			b = 1;
		return b;
	endfunction

	function automatic void sound(input int r, input int unsigned gate);
		pitch = pitch_hz(r);
		tone_live = 1'b1;
		gate_left = gate[11:0];
	endfunction

	function automatic res_t advance_sequencer(input beat_t b);
		res_t o;
		int unsigned tps;
		int unsigned dur;
		logic started;
		logic stopped;
		logic hit;
		started = 1'b0;
		stopped = 1'b0;
		case (b.op)
			OP_TICK: begin
				if (tone_live) begin
					if (gate_left <= 1) begin
						gate_left = '0;
						tone_live = 1'b0;
						stopped = 1'b1;
					end else begin
						gate_left = gate_left - 1'b1;
					end
				end
				if (running) begin
					tps = step_ticks(tempo_sel);
					beat_acc = beat_acc + 1'b1;
					if (beat_acc >= tps) begin
						beat_acc = '0;
						if (awaiting_first) begin
							playhead = '0;
							awaiting_first = 1'b0;
						end else begin
							playhead = playhead + 1'b1;   // 16 columns: 4-bit wrap
						end
						hit = 1'b0;
						for (int r = 0; r < ROWS; r++) begin
							if (!hit && cells[r][playhead]) begin
								hit = 1'b1;
								dur = (tps * 6) / 10;
								if (dur < 1)
									dur = 1;
								sound(r, dur);
								started = 1'b1;
							end
						end
					end
				end
			end
			OP_TOGGLE: begin
				if (b.row < ROWS) begin
					cells[b.row][b.col] = ~cells[b.row][b.col];
					if (cells[b.row][b.col]) begin
						sound(b.row, aud_ticks);
						started = 1'b1;
					end
				end
			end
			OP_PLAY: begin
				running = ~running;
				playhead = '0;
				awaiting_first = 1'b1;
				beat_acc = '0;
				if (!running) begin
					stopped = tone_live;
					tone_live = 1'b0;
					gate_left = '0;
				end
			end
			OP_CLEAR: begin
				for (int r = 0; r < ROWS; r++)
					cells[r] = '0;
			end
			OP_TEMPO_DOWN: begin
				if (tempo_sel > 0)
					tempo_sel = tempo_sel - 1'b1;
			end
			OP_TEMPO_UP: begin
				if (tempo_sel < TEMPO_MAX)
					tempo_sel = tempo_sel + 1'b1;
			end
			default: ;
		endcase
		o.tone_on = tone_live;
		o.tone_freq = pitch;
		o.tone_start = started;
		o.tone_stop = stopped;
		o.step_now = playhead;
		o.is_playing = running;
		o.tempo_bpm = 8'(tempo_hz(tempo_sel));
		return o;
	endfunction

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// sender: one beat per handshake, random gap bursts
	always @(posedge clk) begin : driver
		beat_t nxt;
		if (arst_n && (!req_valid || !req_stall)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (pending_events.size() == 0) begin
				req_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				send_gap <= $urandom_range(0, 3);
				req_valid <= 1'b0;
			end else begin
				nxt = pending_events.pop_front();
				req_valid <= 1'b1;
				op <= nxt.op;
				row <= nxt.row;
				col <= nxt.col;
			end
		end
	end

	// receiver: check results first, then predict the beat taken at this edge
	always @(posedge clk) begin : monitor
		res_t want;
		beat_t taken;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_tones.size() == 0) begin
					$display("%0t: result with none expected, actual freq %0d step %0d",
						$time, tone_freq, step_now);
					mismatches++;
				end else begin
					want = expected_tones.pop_front();
					check_field("tone_on", want.tone_on, tone_on);
					check_field("tone_freq", want.tone_freq, tone_freq);
					check_field("tone_start", want.tone_start, tone_start);
					check_field("tone_stop", want.tone_stop, tone_stop);
					check_field("step_now", want.step_now, step_now);
					check_field("is_playing", want.is_playing, is_playing);
					check_field("tempo_bpm", want.tempo_bpm, tempo_bpm);
					results_seen++;
					starts_seen += want.tone_start;
					stops_seen += want.tone_stop;
					both_seen += want.tone_start & want.tone_stop;
				end
			end
			if (req_valid && !req_stall) begin
				taken.op = op;
				taken.row = row;
				taken.col = col;
				expected_tones.push_back(advance_sequencer(taken));
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(0, 3);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, expected_tones.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic void add_event(input logic [2:0] o, input logic [3:0] r, input logic [3:0] c);
		beat_t b;
		b.op = o;
		b.row = r;
		b.col = c;
		pending_events.push_back(b);
	endfunction

	function automatic void add_random_events(input int n);
		int pick;
		logic [2:0] dir;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 999);
			if (pick < 600) begin
				add_event(OP_TICK, 4'($urandom), 4'($urandom));
			end else if (pick < 820) begin
				// mostly in-grid cells, some out of range rows
				if ($urandom_range(0, 9) == 0)
					add_event(OP_TOGGLE, 4'($urandom_range(12, 15)), 4'($urandom));
				else
					add_event(OP_TOGGLE, 4'($urandom_range(0, 11)), 4'($urandom));
			end else if (pick < 835) begin
				add_event(OP_PLAY, 4'($urandom), 4'($urandom));
			end else if (pick < 850) begin
				add_event(OP_CLEAR, 4'($urandom), 4'($urandom));
			end else if (pick < 900) begin
				add_event(OP_TEMPO_DOWN, 4'($urandom), 4'($urandom));
			end else if (pick < 950) begin
				add_event(OP_TEMPO_UP, 4'($urandom), 4'($urandom));
			end else if (pick < 965) begin
				// sweep into a tempo limit
				dir = $urandom_range(0, 1) ? OP_TEMPO_UP : OP_TEMPO_DOWN;
				for (int j = 0; j < 22; j++)
					add_event(dir, 4'($urandom), 4'($urandom));
				k += 21;
			end else begin
				add_event($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI,
					4'($urandom), 4'($urandom));
			end
		end
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || req_valid || expected_tones.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_audition(input logic [11:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		aud_ticks = v;
	endtask

	task automatic run_phase(input logic [11:0] gate, input int n);
		write_audition(gate);
		@(negedge clk);
		if (!running)
			add_event(OP_PLAY, 4'd0, 4'd0);
		add_random_events(n);
		wait_drained();
	endtask

	initial begin
		for (int r = 0; r < ROWS; r++)
			cells[r] = '0;
		running = 1'b0;
		playhead = '0;
		awaiting_first = 1'b0;
		beat_acc = '0;
		tempo_sel = TEMPO_RESET;
		tone_live = 1'b0;
		gate_left = '0;
		pitch = '0;
		aud_ticks = AUDITION_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: unused codes, grid corners, out-of-grid cells, tempo and play edges
		@(negedge clk);
		add_event(OP_TICK, 4'd15, 4'd15);
		add_event(OP_SPARE_LO, 4'd0, 4'd0);
		add_event(OP_SPARE_HI, 4'd15, 4'd15);
		add_event(OP_TOGGLE, 4'd0, 4'd0);
		add_event(OP_TOGGLE, 4'd11, 4'd15);
		add_event(OP_TOGGLE, 4'd12, 4'd3);
		add_event(OP_TOGGLE, 4'd15, 4'd15);
		add_event(OP_TOGGLE, 4'd11, 4'd15);
		add_event(OP_CLEAR, 4'd0, 4'd0);
		add_event(OP_TICK, 4'd0, 4'd0);
		add_event(OP_TEMPO_UP, 4'd0, 4'd0);
		add_event(OP_TEMPO_DOWN, 4'd0, 4'd0);
		add_event(OP_TOGGLE, 4'd5, 4'd0);
		add_event(OP_TOGGLE, 4'd2, 4'd1);
		add_event(OP_PLAY, 4'd0, 4'd0);
		for (int k = 0; k < 9; k++)
			add_event(OP_TEMPO_UP, 4'd0, 4'd0);
		add_event(OP_TICK, 4'd0, 4'd0);
		wait_drained();

		run_phase(12'd1, 330);
		run_phase(12'd0, 330);
		run_phase(12'd4095, 330);
		run_phase(12'($urandom_range(1, 30)), 330);
		run_phase(12'($urandom_range(1, 4095)), 330);
		idle_on = 1'b0;
		run_phase(12'd9, 330);

		$display("Checked %0d results: %0d tone starts, %0d stops, %0d with both on one tick.",
			results_seen, starts_seen, stops_seen, both_seen);
		$display("Audition gates 200, 1, 0, 4095 and random; tempo swept to both limits.");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== note_step_sequencer.f =====
+incdir+rtl/core
rtl/core/nss_pkg.sv
rtl/core/nss_in_stage.sv
rtl/core/nss_engine.sv
rtl/core/nss_out_stage.sv
rtl/core/note_step_sequencer.sv
rtl/core/nss_checker.sv
tb/note_step_sequencer_test.sv
